// ===== src/lalr_pkg.sv =====
// Shared types and constants of the line resampler.
package lalr_pkg;

    localparam int LEN_W         = 13;
    localparam int SAMPLE_W      = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_RESULTS   = 32;
    localparam int CNT_W         = 6;
    localparam int CFG_IDX_W     = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IN_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd3;

    typedef enum logic [1:0] {
        SRC_BIN,
        SRC_ACC,
        SRC_SAMPLE
    } emit_src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCHK,
        ST_MULW,
        ST_ACC,
        ST_EMIT_BIN,
        ST_LASTCHK,
        ST_FLUSH,
        ST_ECHK,
        ST_IW,
        ST_IM1,
        ST_IM2,
        ST_EMIT_INT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic      load;
        logic      piece;
        logic      piece_tail;
        logic      mulw;
        logic      acc;
        logic      w1;
        logic      m1;
        logic      m2;
        logic      emit;
        emit_src_t emit_src;
        logic      finish;
    } dp_cmd_t;

    typedef struct packed {
        logic shrink;
        logic first;
        logic last;
        logic can_emit;
        logic idx_lt_len;
        logic pos_le_hi;
        logic pos_lt0;
        logic pos_lt_lo;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== src/lalr_ctrl.sv =====
// Sequencer of the line resampler: walks one input request through its steps.
module lalr_ctrl
    import lalr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   tail_reg, tail_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tail_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        tail_next  = tail_reg;
        cmd        = '0;
        cmd.emit_src = SRC_BIN;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.shrink ? ST_SCHK : ST_ECHK;
                end
            end
            // shrink: close bins that end inside this sample, then the tail piece
            ST_SCHK:
            begin
                if (sts.can_emit && sts.pos_le_hi)
                begin
                    cmd.piece  = 1'b1;
                    tail_next  = 1'b0;
                    state_next = ST_MULW;
                end
                else if (sts.idx_lt_len && !sts.pos_le_hi)
                begin
                    cmd.piece      = 1'b1;
                    cmd.piece_tail = 1'b1;
                    tail_next      = 1'b1;
                    state_next     = ST_MULW;
                end
                else
                begin
                    state_next = ST_LASTCHK;
                end
            end
            ST_MULW:
            begin
                cmd.mulw   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = tail_reg ? ST_LASTCHK : ST_EMIT_BIN;
            end
            ST_EMIT_BIN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_BIN;
                    state_next   = ST_SCHK;
                end
            end
            ST_LASTCHK:
            begin
                state_next = sts.last ? ST_FLUSH : ST_FINISH;
            end
            // line end: remaining bins or the last sample
            ST_FLUSH:
            begin
                if (!sts.can_emit)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = sts.shrink ? SRC_BIN : SRC_SAMPLE;
                end
            end
            // enlarge: edge clamp on the first sample, interpolation after
            ST_ECHK:
            begin
                if (sts.first)
                begin
                    if (sts.can_emit && sts.pos_lt0)
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_src = SRC_SAMPLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_LASTCHK;
                    end
                end
                else if (sts.can_emit && sts.pos_lt_lo)
                begin
                    state_next = ST_IW;
                end
                else
                begin
                    state_next = ST_LASTCHK;
                end
            end
            ST_IW:
            begin
                cmd.w1     = 1'b1;
                state_next = ST_IM1;
            end
            ST_IM1:
            begin
                cmd.m1     = 1'b1;
                state_next = ST_IM2;
            end
            ST_IM2:
            begin
                cmd.m2     = 1'b1;
                state_next = ST_EMIT_INT;
            end
            ST_EMIT_INT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_ACC;
                    state_next   = ST_ECHK;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lalr_dp.sv =====
// Datapath of the line resampler: registers, position arithmetic, multipliers, output stage.
module lalr_dp
    import lalr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SAMPLE_W-1:0]    sample_in,
    input  logic                   cfg_valid,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [LEN_W+FRAC_BITS-1:0] cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_W-1:0]    sample_out,
    output logic                   line_last,
    input  dp_cmd_t                cmd,
    output dp_sts_t                sts
);

    localparam int F      = FRAC_BITS;
    localparam int STEP_W = LEN_W + F;
    localparam int GAIN_W = F + 1;
    localparam int PW     = STEP_W + 16;
    localparam int W_W    = F + 2;
    localparam int BIN_W  = F + 31;
    localparam int ACC_W  = F + 17;
    localparam int ONE    = 1 << F;
    localparam logic signed [PW-1:0] ONE_P  = PW'(ONE);
    localparam logic signed [PW-1:0] HALF_P = PW'(ONE / 2);
    localparam logic signed [PW-1:0] SKIP_P = PW'(ONE / 1000);
    localparam logic [SAMPLE_W-1:0]  SAT    = '1;

    logic [LEN_W-1:0]    in_len_reg, out_len_reg, in_len_n, out_len_n;
    logic [STEP_W-1:0]   step_reg, step_n;
    logic [GAIN_W-1:0]   gain_reg, gain_n;
    logic [LEN_W-1:0]    in_index_reg, out_index_reg;
    logic signed [PW-1:0] position_reg, start_reg;
    logic [BIN_W-1:0]    bin_sum_reg;
    logic [SAMPLE_W-1:0] prev_reg, s_reg;
    logic                last_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [F:0]          len_reg, w1_reg;
    logic                len_ok_reg;
    logic [W_W-1:0]      w_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] sample_out_reg;
    logic                line_last_reg;

    logic                 cfg_we, shrink, shrink_n;
    logic [LEN_W-1:0]     eff_in, eff_in_n;
    logic signed [PW-1:0] lo, hi, pos_init, len_full, d_full, pos_step;
    logic [2*GAIN_W-1:0]  wprod;
    logic [ACC_W-1:0]     interp_round;
    logic [BIN_W-1:0]     bin_round;
    logic [SAMPLE_W-1:0]  emit_val;
    logic                 out_free;

    // register values after a write in this cycle, for the line restart
    always_comb
    begin
        cfg_we    = cfg_valid;
        in_len_n  = in_len_reg;
        out_len_n = out_len_reg;
        step_n    = step_reg;
        gain_n    = gain_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IN_LEN:  in_len_n  = cfg_data[LEN_W-1:0];
                REG_OUT_LEN: out_len_n = cfg_data[LEN_W-1:0];
                REG_STEP:    step_n    = cfg_data;
                REG_GAIN:    gain_n    = cfg_data[GAIN_W-1:0];
                default:     in_len_n  = in_len_reg;
            endcase
        end
    end

    // mode and line-start position
    assign eff_in   = (in_len_reg == '0) ? LEN_W'(1) : in_len_reg;
    assign eff_in_n = (in_len_n == '0) ? LEN_W'(1) : in_len_n;
    assign shrink   = out_len_reg < eff_in;
    assign shrink_n = out_len_n < eff_in_n;
    assign pos_init = shrink_n ? signed'(PW'(step_n))
                               : signed'(PW'(step_n >> 1)) - HALF_P;

    // sample span and the pieces of it
    assign lo       = signed'({{(PW-LEN_W-F){1'b0}}, in_index_reg, {F{1'b0}}});
    assign hi       = lo + ONE_P;
    assign len_full = cmd.piece_tail ? (hi - start_reg) : (position_reg - start_reg);
    assign d_full   = position_reg - (lo - ONE_P);
    assign pos_step = position_reg + signed'(PW'(step_reg));
    assign wprod    = len_reg * gain_reg + (2*GAIN_W)'(ONE / 2);

    // rounded results
    assign bin_round    = bin_sum_reg + BIN_W'(ONE / 2);
    assign interp_round = acc_reg + ACC_W'(ONE / 2);
    always_comb
    begin
        unique case (cmd.emit_src)
            SRC_BIN:
                emit_val = (bin_round[BIN_W-1:F] > (BIN_W-F)'(SAT)) ? SAT
                           : bin_round[F+SAMPLE_W-1:F];
            SRC_ACC:
                emit_val = (interp_round[ACC_W-1:F] > (ACC_W-F)'(SAT)) ? SAT
                           : interp_round[F+SAMPLE_W-1:F];
            default:
                emit_val = s_reg;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    // control state: registers, line counters, position, bin sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_len_reg    <= LEN_W'(2);
            out_len_reg   <= LEN_W'(2);
            step_reg      <= STEP_W'(ONE);
            gain_reg      <= GAIN_W'(ONE);
            in_index_reg  <= '0;
            out_index_reg <= '0;
            position_reg  <= '0;
            start_reg     <= '0;
            bin_sum_reg   <= '0;
            prev_reg      <= '0;
            last_reg      <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                start_reg <= lo;
                n_reg     <= '0;
                last_reg  <= ({1'b0, in_index_reg} + (LEN_W+1)'(1)) >= {1'b0, eff_in};
            end
            if (cmd.acc)
            begin
                bin_sum_reg <= bin_sum_reg + BIN_W'(s_reg * w_reg);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                out_index_reg <= out_index_reg + LEN_W'(1);
                position_reg  <= pos_step;
                n_reg         <= n_reg + CNT_W'(1);
                if (cmd.emit_src == SRC_BIN)
                begin
                    bin_sum_reg <= '0;
                    if (position_reg > start_reg)
                    begin
                        start_reg <= position_reg;
                    end
                end
            end
            // line restart at the last sample or on a register write
            if ((cmd.finish && last_reg) || cfg_we)
            begin
                in_index_reg  <= '0;
                out_index_reg <= '0;
                bin_sum_reg   <= '0;
                prev_reg      <= '0;
                position_reg  <= pos_init;
            end
            else if (cmd.finish)
            begin
                prev_reg     <= s_reg;
                in_index_reg <= in_index_reg + LEN_W'(1);
            end
            in_len_reg  <= in_len_n;
            out_len_reg <= out_len_n;
            step_reg    <= step_n;
            gain_reg    <= gain_n;
        end
    end

    // payload: sample, piece weight, interpolation accumulator, output data
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_reg <= sample_in;
        end
        if (cmd.piece)
        begin
            len_ok_reg <= len_full > SKIP_P;
            len_reg    <= len_full[F:0];
        end
        if (cmd.mulw)
        begin
            w_reg <= len_ok_reg ? wprod[F+W_W-1:F] : '0;
        end
        if (cmd.w1)
        begin
            if (d_full < 0)
                w1_reg <= '0;
            else if (d_full > ONE_P)
                w1_reg <= (F+1)'(ONE);
            else
                w1_reg <= d_full[F:0];
        end
        if (cmd.m1)
        begin
            acc_reg <= ACC_W'(prev_reg * ((F+1)'(ONE) - w1_reg));
        end
        if (cmd.m2)
        begin
            acc_reg <= acc_reg + ACC_W'(s_reg * w1_reg);
        end
        if (cmd.emit)
        begin
            sample_out_reg <= emit_val;
            line_last_reg  <= ({1'b0, out_index_reg} + (LEN_W+1)'(1)) == {1'b0, out_len_reg};
        end
    end

    // status to the sequencer
    always_comb
    begin
        sts.shrink     = shrink;
        sts.first      = in_index_reg == '0;
        sts.last       = last_reg;
        sts.idx_lt_len = out_index_reg < out_len_reg;
        sts.can_emit   = (out_index_reg < out_len_reg) && (n_reg < CNT_W'(MAX_RESULTS));
        sts.pos_le_hi  = position_reg <= hi;
        sts.pos_lt0    = position_reg < 0;
        sts.pos_lt_lo  = position_reg < lo;
        sts.out_free   = out_free;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign line_last  = line_last_reg;

endmodule

// ===== src/line_area_linear_resampler.sv =====
// Top level of the one-dimensional line resampler.
//
// Input channel (in_valid/in_ready/sample_in) takes one Q8.8 sample per
// request; output channel (out_valid/out_ready/sample_out/line_last) gives
// resampled Q8.8 samples, line_last on the final sample of a line.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
// in_len, out_len, step and gain; any write restarts the current line.
// One sample is handled at a time by the sequencer. Shrinking walks each
// sample through SCHK and, per finished bin, MULW, ACC and EMIT_BIN, with a
// partial tail piece through MULW and ACC; enlarging walks IW, IM1, IM2 and
// EMIT_INT per interpolated result. An issued result is held in the output
// register until the receiver takes it.
// Reset restores in_len = out_len = 2, step = gain = 1.0 and an empty line.
// When the receiver stalls the output register holds its request and the
// sequencer waits for it to drain before the next result; the input side
// is taken again only when the current sample is finished.
module line_area_linear_resampler
    import lalr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [SAMPLE_W-1:0]        sample_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [SAMPLE_W-1:0]        sample_out,
    output logic                       line_last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [LEN_W+FRAC_BITS-1:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    lalr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lalr_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .line_last  (line_last),
        .cmd        (cmd),
        .sts        (sts)
    );

    // the sequencer leaves idle once a sample is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // a new result shows up only while a sample is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("result raised while idle");

    // results are only issued into a free output register, within the line and per-sample limits
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free && sts.can_emit)
        else $error("result issued into busy output or beyond cap");

endmodule

// ===== tb/lalr_checker.sv =====
// Predictor and scoreboard for the line resampler: watches all three channels.
module lalr_checker
    import lalr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [SAMPLE_W-1:0]      sample_in,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [SAMPLE_W-1:0]      sample_out,
    input  logic                     line_last,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [LEN_W+FRAC_BITS_DEF-1:0] cfg_data,
    output int                       errors,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE   = 64'd1 << FRAC_BITS_DEF;
    localparam longint HALF  = 64'd1 << (FRAC_BITS_DEF - 1);
    localparam longint SLIVER = ONE / 1000;

    typedef struct {
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } pixel_t;

    pixel_t pixel_q[$];

    // shadow registers and line state
    logic [12:0] len_in, len_out;
    logic [28:0] step_q;
    logic [16:0] gain_q;
    int unsigned col_in, col_out;
    longint      pos;
    longint unsigned area_acc;
    longint      prev_px;

    function automatic longint eff_in();
        return (len_in == 0) ? 1 : longint'(len_in);
    endfunction

    function automatic bit shrinking();
        return longint'(len_out) < eff_in();
    endfunction

    task automatic restart_line();
        col_in   = 0;
        col_out  = 0;
        area_acc = 0;
        prev_px  = 0;
        if (shrinking())
            pos = longint'(step_q);
        else
            pos = longint'(step_q >> 1) - HALF;
    endtask

    task automatic push_pixel(input longint unsigned v, inout int n);
        pixel_t p;
        p.value = (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
        p.last  = (col_out + 1 == len_out);
        pixel_q.push_back(p);
        col_out++;
        n++;
    endtask

    task automatic add_area(input longint s, input longint len);
        longint unsigned w;
        if (len > SLIVER) begin
            w = (longint'(len) * longint'(gain_q) + HALF) >> FRAC_BITS_DEF;
            area_acc += s * w;
        end
    endtask

    function automatic bit room(int n);
        return (col_out < len_out) && (n < MAX_RESULTS);
    endfunction

    // expected pixels caused by one accepted sample
    task automatic predict_pixels(input logic [SAMPLE_W-1:0] px);
        longint s, lo, hi, start, base, d, w1;
        bit     last;
        int     n;
        s    = px;
        last = (longint'(col_in) + 1 >= eff_in());
        lo   = longint'(col_in) << FRAC_BITS_DEF;
        hi   = lo + ONE;
        n    = 0;
        if (shrinking())
        begin
            start = lo;
            while (room(n) && pos <= hi)
            begin
                add_area(s, pos - start);
                push_pixel((area_acc + HALF) >> FRAC_BITS_DEF, n);
                area_acc = 0;
                if (pos > start) start = pos;
                pos += longint'(step_q);
            end
            if (col_out < len_out && pos > hi) add_area(s, hi - start);
            if (last)
                while (room(n))
                begin
                    push_pixel((area_acc + HALF) >> FRAC_BITS_DEF, n);
                    area_acc = 0;
                end
        end
        else
        begin
            if (col_in == 0)
            begin
                while (room(n) && pos < 0)
                begin
                    push_pixel(s, n);
                    pos += longint'(step_q);
                end
            end
            else
            begin
                base = lo - ONE;
                while (room(n) && pos < lo)
                begin
                    d  = pos - base;
                    w1 = (d < 0) ? 0 : ((d > ONE) ? ONE : d);
                    push_pixel((prev_px * (ONE - w1) + s * w1 + HALF) >> FRAC_BITS_DEF, n);
                    pos += longint'(step_q);
                end
            end
            if (last)
                while (room(n))
                begin
                    push_pixel(s, n);
                    pos += longint'(step_q);
                end
        end
        if (last)
            restart_line();
        else
        begin
            prev_px = s;
            col_in  = (col_in + 1) & 13'h1FFF;
        end
    endtask

    assign pending = pixel_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t exp_px;
        if (!rst_n)
        begin
            len_in  = 2;
            len_out = 2;
            step_q  = 29'(ONE);
            gain_q  = 17'(ONE);
            restart_line();
            pixel_q.delete();
            errors = 0;
        end
        else
        begin
            // results first: they stem from earlier requests
            if (out_valid && out_ready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $error("unexpected output sample_out=%0h line_last=%0b",
                           sample_out, line_last);
                    errors++;
                end
                else
                begin
                    exp_px = pixel_q.pop_front();
                    if (sample_out !== exp_px.value)
                    begin
                        $error("sample_out expected %0h actual %0h", exp_px.value, sample_out);
                        errors++;
                    end
                    if (line_last !== exp_px.last)
                    begin
                        $error("line_last expected %0b actual %0b", exp_px.last, line_last);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IN_LEN:  len_in  = cfg_data[12:0];
                    REG_OUT_LEN: len_out = cfg_data[12:0];
                    REG_STEP:    step_q  = cfg_data[28:0];
                    REG_GAIN:    gain_q  = cfg_data[16:0];
                    default: ;
                endcase
                restart_line();
            end
            if (in_valid && in_ready) predict_pixels(sample_in);
        end
    end
endmodule

// ===== tb/testbench.sv =====
// Top of the resampler testbench: clock, reset, stimulus and verdict.
module testbench;
    import lalr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [SAMPLE_W-1:0]        sample_in = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [SAMPLE_W-1:0]        sample_out;
    logic                       line_last;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [LEN_W+FRAC_BITS_DEF-1:0] cfg_data = '0;
    int                         errors;
    int                         pending;
    bit                         calm = 1'b0;
    int                         rand_items = 0;

    line_area_linear_resampler DUT (.*);

    lalr_checker scoreboard (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mostly no gap, sometimes a short one, now and then a long one
    function automatic int gap_len();
        if (calm) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // receiver stalls
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            g = gap_len();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
        end
    end

    // one sample request; returns at a falling edge
    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        int g;
        in_valid  <= 1'b1;
        sample_in <= v;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [LEN_W+FRAC_BITS_DEF-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // stop requests, drain, let the sequencer settle, then load all four registers
    task automatic set_mode(input int li, input int lo, input longint stp, input longint gn);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        write_reg(REG_IN_LEN, (LEN_W+FRAC_BITS_DEF)'(li));
        write_reg(REG_OUT_LEN, (LEN_W+FRAC_BITS_DEF)'(lo));
        write_reg(REG_STEP, (LEN_W+FRAC_BITS_DEF)'(stp));
        write_reg(REG_GAIN, (LEN_W+FRAC_BITS_DEF)'(gn));
    endtask

    task automatic set_ratio(input int li, input int lo);
        set_mode(li, lo, (longint'(li) << 16) / lo, (longint'(lo) << 16) / li);
    endtask

    task automatic run_lines(input int li, input int lines);
        repeat (lines * li) send_sample(SAMPLE_W'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        int li, lo;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset setting: copy, then sample extremes and bit patterns
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'hAAAA);
        send_sample(16'h5555);
        // shrink with sums that saturate
        set_ratio(3, 2);
        calm = 1'b1;
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        calm = 1'b0;
        // largest enlarge ratio
        set_ratio(2, 32);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        // whole line into one bin, full gain
        set_mode(8, 1, longint'(8 << 16), longint'(65536));
        run_lines(8, 1);
        // smallest step with equal lengths: deferred results, zero gain
        set_mode(4, 4, longint'(4096), longint'(0));
        run_lines(4, 1);
        // long output line
        set_ratio(64, 1024);
        run_lines(64, 1);

        // random settings, whole lines mostly, some cut short
        while (rand_items < 60)
        begin
            li = $urandom_range(2, 12);
            lo = $urandom_range(1, li * 16);
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
                set_mode(li, lo, longint'($urandom_range(4096, 1 << 20)),
                         longint'($urandom_range(0, 65536)));
            else
                set_ratio(li, lo);
            repeat ($urandom_range(1, 3))
            begin
                run_lines(li, 1);
                rand_items += li;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, li - 1))
                    send_sample(SAMPLE_W'($urandom_range(0, 65535)));
                rand_items++;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
